// File: rtl/dltq_pkg.sv
// dltq_pkg: types, constants and codes for the delta list timer queue.
// Used by every module of the block; depends on nothing.
`default_nettype none
package dltq_pkg;
	localparam int NUM_TIMERS = 16;
	localparam int COUNT_BITS = 32;
	localparam int IDX_BITS = $clog2(NUM_TIMERS);
	localparam int OCC_BITS = $clog2(NUM_TIMERS + 1);

	localparam logic [1:0] KIND_TICK = 2'd0;
	localparam logic [1:0] KIND_ATTACH = 2'd1;
	localparam logic [1:0] KIND_DETACH = 2'd2;

	localparam logic [2:0] EV_NONE = 3'd0;
	localparam logic [2:0] EV_EXPIRED = 3'd1;
	localparam logic [2:0] EV_DETACHED = 3'd2;
	localparam logic [2:0] EV_NOT_FOUND = 3'd3;
	localparam logic [2:0] EV_REJECTED = 3'd4;

	typedef struct packed {
		logic [1:0] kind;
		logic [3:0] timer_id;
		logic [31:0] amount;
	} in_word_t;

	typedef struct packed {
		logic [3:0] timer_id_res;
		logic [2:0] event_res;
		logic last;
	} out_word_t;

	typedef enum logic [2:0] {
		OP_LOAD = 3'd0,
		OP_TICK = 3'd1,
		OP_POP = 3'd2,
		OP_FIND_INS = 3'd3,
		OP_INSERT = 3'd4,
		OP_FIND_DET = 3'd5,
		OP_REMOVE = 3'd6,
		OP_NOP = 3'd7
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic [IDX_BITS-1:0] idx;
	} dp_cmd_t;

	typedef struct packed {
		logic [OCC_BITS-1:0] occ;
		logic head_zero;
		logic n_zero;
		logic ins_here;
		logic ins_after;
		logic match;
		logic [3:0] head_id;
		logic active;
	} dp_stat_t;
endpackage
`default_nettype wire

// File: rtl/dltq_datapath.sv
// dltq_datapath: entry registers, working count, active mask and occupancy.
// Depends on dltq_pkg; driven by dltq_ctrl one step per cycle.
`default_nettype none
module dltq_datapath (
	input wire logic clk,
	input wire logic arst_n,
	input wire dltq_pkg::in_word_t in_word,
	input wire dltq_pkg::dp_cmd_t cmd,
	output dltq_pkg::dp_stat_t stat
);
	localparam int N = dltq_pkg::NUM_TIMERS;
	localparam int CB = dltq_pkg::COUNT_BITS;
	localparam int IB = dltq_pkg::IDX_BITS;
	localparam int OB = dltq_pkg::OCC_BITS;

	logic [3:0] ids_q [N];
	logic [CB-1:0] deltas_q [N];
	logic [OB-1:0] occ_q;
	logic [N-1:0] active_q;
	logic [CB-1:0] n_q;
	logic [3:0] id_q;
	logic [IB-1:0] idx;
	logic [CB-1:0] cur;
	logic [CB-1:0] amt_sat;

	assign idx = cmd.idx;
	assign cur = deltas_q[idx];
	assign amt_sat = (CB >= 32) ? CB'(in_word.amount)
		: ((|(in_word.amount >> CB)) ? {CB{1'b1}} : CB'(in_word.amount));

	always_comb begin
		stat.occ = occ_q;
		stat.head_zero = (deltas_q[0] == '0);
		stat.n_zero = (n_q == '0);
		stat.ins_here = (n_q < cur);
		stat.ins_after = (n_q == cur);
		stat.match = (ids_q[idx] == id_q);
		stat.head_id = ids_q[0];
		stat.active = active_q[in_word.timer_id[IB-1:0]] && ({28'd0, in_word.timer_id} < N);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
			active_q <= '0;
		end else begin
			case (cmd.op)
				dltq_pkg::OP_POP: begin
					occ_q <= occ_q - OB'(1);
					active_q[ids_q[0][IB-1:0]] <= 1'b0;
				end
				dltq_pkg::OP_INSERT: begin
					occ_q <= occ_q + OB'(1);
					active_q[id_q[IB-1:0]] <= 1'b1;
				end
				dltq_pkg::OP_REMOVE: begin
					occ_q <= occ_q - OB'(1);
					active_q[id_q[IB-1:0]] <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			dltq_pkg::OP_LOAD: begin
				n_q <= amt_sat;
				id_q <= in_word.timer_id;
			end
			dltq_pkg::OP_TICK: begin
				if (n_q <= deltas_q[0]) begin
					deltas_q[0] <= deltas_q[0] - n_q;
					n_q <= '0;
				end else begin
					n_q <= n_q - deltas_q[0];
					deltas_q[0] <= '0;
				end
			end
			dltq_pkg::OP_POP: begin
				for (int i = 0; i < N - 1; i++) begin
					ids_q[i] <= ids_q[i+1];
					deltas_q[i] <= deltas_q[i+1];
				end
			end
			dltq_pkg::OP_FIND_INS: n_q <= n_q - cur;
			dltq_pkg::OP_INSERT: begin
				for (int i = 1; i < N; i++) begin
					if (IB'(i) > idx) begin
						ids_q[i] <= ids_q[i-1];
						deltas_q[i] <= deltas_q[i-1];
					end
				end
				ids_q[idx] <= id_q;
				deltas_q[idx] <= n_q;
				if ({1'b0, idx} < occ_q)
					deltas_q[idx+IB'(1)] <= cur - n_q;
			end
			dltq_pkg::OP_REMOVE: begin
				for (int i = 0; i < N - 1; i++) begin
					if (IB'(i) >= idx) begin
						ids_q[i] <= ids_q[i+1];
						deltas_q[i] <= deltas_q[i+1];
					end
				end
				if (OB'(idx) + OB'(1) < occ_q)
					deltas_q[idx] <= deltas_q[idx+IB'(1)] + cur;
			end
			default: begin
			end
		endcase
	end
endmodule
`default_nettype wire

// File: rtl/dltq_ctrl.sv
// dltq_ctrl: sequencer for tick, attach and detach over the entry list.
// Depends on dltq_pkg; commands dltq_datapath and drives the output word.
`default_nettype none
module dltq_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire dltq_pkg::in_word_t in_word,
	output logic out_valid,
	input wire logic out_ready,
	output dltq_pkg::out_word_t out_word,
	output dltq_pkg::dp_cmd_t cmd,
	input wire dltq_pkg::dp_stat_t stat
);
	localparam int IB = dltq_pkg::IDX_BITS;
	localparam int OB = dltq_pkg::OCC_BITS;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_TICK = 5'b00010,
		S_POP = 5'b00100,
		S_INS = 5'b01000,
		S_DET = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic [IB-1:0] idx_q, idx_d;
	logic [3:0] tid_q;
	logic [3:0] pend_id_q;
	logic found_q, found_d;
	logic any_q, any_d;
	logic ov_q, ov_d;
	dltq_pkg::out_word_t ow_q, ow_d;
	logic [OB-1:0] idx_ext;
	logic out_free;

	assign idx_ext = OB'(idx_q);
	assign out_free = !ov_q || out_ready;
	assign in_ready = (state_q == S_IDLE) && out_free;
	assign out_valid = ov_q;
	assign out_word = ow_q;

	always_comb begin
		state_d = state_q;
		idx_d = idx_q;
		found_d = found_q;
		any_d = any_q;
		ov_d = ov_q && !out_ready;
		ow_d = ow_q;
		cmd.op = dltq_pkg::OP_NOP;
		cmd.idx = idx_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid && in_ready) begin
					cmd.op = dltq_pkg::OP_LOAD;
					idx_d = '0;
					found_d = 1'b0;
					any_d = 1'b0;
					case (in_word.kind)
						dltq_pkg::KIND_TICK: state_d = S_TICK;
						dltq_pkg::KIND_ATTACH: begin
							if (stat.active || {28'd0, in_word.timer_id}
									>= dltq_pkg::NUM_TIMERS) begin
								ow_d = '{in_word.timer_id, dltq_pkg::EV_REJECTED, 1'b1};
								ov_d = 1'b1;
							end else if (in_word.amount == '0) begin
								ow_d = '{in_word.timer_id, dltq_pkg::EV_EXPIRED, 1'b1};
								ov_d = 1'b1;
							end else begin
								state_d = S_INS;
							end
						end
						dltq_pkg::KIND_DETACH: begin
							if (stat.active) begin
								state_d = S_DET;
							end else begin
								ow_d = '{in_word.timer_id, dltq_pkg::EV_NOT_FOUND, 1'b1};
								ov_d = 1'b1;
							end
						end
						default: begin
							ow_d = '{4'd0, dltq_pkg::EV_NONE, 1'b1};
							ov_d = 1'b1;
						end
					endcase
				end
			end
			S_TICK: begin
				if (stat.n_zero || stat.occ == '0) begin
					if (out_free) begin
						if (!any_q)
							ow_d = '{4'd0, dltq_pkg::EV_NONE, 1'b1};
						else
							ow_d = '{pend_id_q, dltq_pkg::EV_EXPIRED, 1'b1};
						ov_d = 1'b1;
						state_d = S_IDLE;
					end
				end else begin
					cmd.op = dltq_pkg::OP_TICK;
					state_d = S_POP;
				end
			end
			S_POP: begin
				// an expiry is held back one pop so that last is known when sent
				if (stat.occ != '0 && stat.head_zero) begin
					if (!any_q || out_free) begin
						cmd.op = dltq_pkg::OP_POP;
						any_d = 1'b1;
						if (any_q) begin
							ow_d = '{pend_id_q, dltq_pkg::EV_EXPIRED, 1'b0};
							ov_d = 1'b1;
						end
					end
				end else begin
					state_d = S_TICK;
				end
			end
			S_INS: begin
				if (idx_ext == stat.occ || stat.ins_here) begin
					if (out_free) begin
						cmd.op = dltq_pkg::OP_INSERT;
						ow_d = '{tid_q, dltq_pkg::EV_NONE, 1'b1};
						ov_d = 1'b1;
						state_d = S_IDLE;
					end
				end else if (stat.ins_after) begin
					cmd.op = dltq_pkg::OP_FIND_INS;
					idx_d = idx_q + IB'(1);
					found_d = 1'b1;
				end else begin
					cmd.op = dltq_pkg::OP_FIND_INS;
					idx_d = idx_q + IB'(1);
				end
				if (found_q && out_free) begin
					cmd.op = dltq_pkg::OP_INSERT;
					cmd.idx = idx_q;
					idx_d = idx_q;
					ow_d = '{tid_q, dltq_pkg::EV_NONE, 1'b1};
					ov_d = 1'b1;
					state_d = S_IDLE;
				end else if (found_q) begin
					cmd.op = dltq_pkg::OP_NOP;
					idx_d = idx_q;
					state_d = S_INS;
				end
			end
			S_DET: begin
				if (stat.match) begin
					if (out_free) begin
						cmd.op = dltq_pkg::OP_REMOVE;
						ow_d = '{tid_q, dltq_pkg::EV_DETACHED, 1'b1};
						ov_d = 1'b1;
						state_d = S_IDLE;
					end
				end else begin
					idx_d = idx_q + IB'(1);
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ov_q <= 1'b0;
			idx_q <= '0;
			found_q <= 1'b0;
			any_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ov_q <= ov_d;
			idx_q <= idx_d;
			found_q <= found_d;
			any_q <= any_d;
		end
	end

	always_ff @(posedge clk) begin
		ow_q <= ow_d;
		if (state_q == S_IDLE && in_valid && in_ready)
			tid_q <= in_word.timer_id;
		if (cmd.op == dltq_pkg::OP_POP)
			pend_id_q <= stat.head_id;
	end
endmodule
`default_nettype wire

// File: rtl/delta_list_timer_queue_unit.sv
// delta_list_timer_queue_unit: top level of the delta list timer queue.
// Depends on dltq_pkg, dltq_ctrl and dltq_datapath.
//
// Usage: in/out are valid/ready channels carrying one word each (in_word_t,
// out_word_t). A tick word counts down the head of the list and gives one
// out word per expired timer in list order, last set on the final one, or a
// single word with event 0 when nothing expires. Attach and detach each give
// one word. A rejected or zero-count attach, a detach of an idle timer and an
// unused kind are answered straight from idle; attach and detach otherwise
// walk the list one entry a cycle. A tick alternates between counting down
// the head and popping each expired entry, then closes with its last word.
// One item is worked at a time; the next word is taken in the cycle its
// predecessor's last word is accepted. The walk over the entry registers
// sets the rate.
// Reset empties the list and clears all active flags at once; no clearing
// pass is needed. When the receiver stalls, the output register holds its
// word and the sequencer waits; no word is lost or repeated.
`default_nettype none
module delta_list_timer_queue_unit (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire dltq_pkg::in_word_t in_word,
	output logic out_valid,
	input wire logic out_ready,
	output dltq_pkg::out_word_t out_word
);
	dltq_pkg::dp_cmd_t cmd;
	dltq_pkg::dp_stat_t stat;

	dltq_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
		.out_valid(out_valid), .out_ready(out_ready), .out_word(out_word),
		.cmd(cmd), .stat(stat)
	);

	dltq_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .in_word(in_word),
		.cmd(cmd), .stat(stat)
	);

`ifndef SYNTH
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input accepted while output word pending");
	a_occ_range: assert property (@(posedge clk) disable iff (!arst_n)
		stat.occ <= dltq_pkg::OCC_BITS'(dltq_pkg::NUM_TIMERS))
		else $error("occupancy out of range");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output word dropped");
`endif
endmodule
`default_nettype wire

// File: tb/delta_list_timer_queue_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for delta_list_timer_queue_unit: directed and random
// tick/attach/detach words checked against an in-bench delta list model.
// Depends on dltq_pkg and the RTL of the timer queue.
module delta_list_timer_queue_unit_tb;
	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	dltq_pkg::in_word_t in_word;
	logic out_valid;
	logic out_ready;
	dltq_pkg::out_word_t out_word;

	delta_list_timer_queue_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_word(in_word),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_word(out_word)
	);

	// model of the list
	logic [3:0] list_ids [dltq_pkg::NUM_TIMERS];
	logic [31:0] list_deltas [dltq_pkg::NUM_TIMERS];
	int list_occ;
	logic [15:0] active_ids;

	dltq_pkg::out_word_t pending_words[$];
	int errors;
	int words_in;
	int words_out;
	int send_idle_pct;
	int recv_idle_pct;
	int hold_left;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("simulation failed");
		$finish;
	end

	function automatic void list_remove(int pos);
		for (int i = pos; i + 1 < list_occ; i++) begin
			list_ids[i] = list_ids[i + 1];
			list_deltas[i] = list_deltas[i + 1];
		end
		list_occ--;
	endfunction

	function automatic void list_insert(int pos, logic [3:0] id, logic [31:0] delta);
		for (int i = list_occ; i > pos; i--) begin
			list_ids[i] = list_ids[i - 1];
			list_deltas[i] = list_deltas[i - 1];
		end
		list_ids[pos] = id;
		list_deltas[pos] = delta;
		list_occ++;
	endfunction

	function automatic void insert_by_expiry(logic [3:0] id, logic [31:0] count);
		logic [31:0] c;
		c = count;
		for (int i = 0; i < list_occ; i++) begin
			if (c < list_deltas[i]) begin
				list_deltas[i] = list_deltas[i] - c;
				list_insert(i, id, c);
				return;
			end
			c = c - list_deltas[i];
			if (c == 0) begin
				list_insert(i + 1, id, 32'd0);
				return;
			end
		end
		list_insert(list_occ, id, c);
	endfunction

	function automatic void push_word(logic [3:0] id, logic [2:0] ev, logic lst);
		dltq_pkg::out_word_t e;
		e.timer_id_res = id;
		e.event_res = ev;
		e.last = lst;
		pending_words.push_back(e);
	endfunction

	function automatic void predict_results(dltq_pkg::in_word_t w);
		logic [31:0] n;
		logic [3:0] eid;
		dltq_pkg::out_word_t e;
		int k;
		k = 0;
		case (w.kind)
			dltq_pkg::KIND_TICK: begin
				n = w.amount;
				while (n != 0 && list_occ != 0) begin
					if (n <= list_deltas[0]) begin
						list_deltas[0] = list_deltas[0] - n;
						n = 0;
					end else begin
						n = n - list_deltas[0];
						list_deltas[0] = 0;
					end
					while (list_occ != 0 && list_deltas[0] == 0) begin
						eid = list_ids[0];
						list_remove(0);
						active_ids[eid] = 1'b0;
						push_word(eid, dltq_pkg::EV_EXPIRED, 1'b0);
						k++;
					end
				end
				if (k == 0) begin
					push_word(4'd0, dltq_pkg::EV_NONE, 1'b1);
				end else begin
					e = pending_words.pop_back();
					e.last = 1'b1;
					pending_words.push_back(e);
				end
			end
			dltq_pkg::KIND_ATTACH: begin
				if (active_ids[w.timer_id]) begin
					push_word(w.timer_id, dltq_pkg::EV_REJECTED, 1'b1);
				end else if (w.amount == 0) begin
					push_word(w.timer_id, dltq_pkg::EV_EXPIRED, 1'b1);
				end else begin
					insert_by_expiry(w.timer_id, w.amount);
					active_ids[w.timer_id] = 1'b1;
					push_word(w.timer_id, dltq_pkg::EV_NONE, 1'b1);
				end
			end
			dltq_pkg::KIND_DETACH: begin
				if (active_ids[w.timer_id]) begin
					for (int i = 0; i < list_occ; i++) begin
						if (list_ids[i] == w.timer_id && k == 0) begin
							if (i + 1 < list_occ)
								list_deltas[i + 1] = list_deltas[i + 1] + list_deltas[i];
							list_remove(i);
							active_ids[w.timer_id] = 1'b0;
							k = 1;
						end
					end
				end
				push_word(w.timer_id, k ? dltq_pkg::EV_DETACHED : dltq_pkg::EV_NOT_FOUND,
					1'b1);
			end
			default: begin
				push_word(4'd0, dltq_pkg::EV_NONE, 1'b1);
			end
		endcase
	endfunction

	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		dltq_pkg::out_word_t e;
		if (arst_n && out_valid && out_ready) begin
			words_out++;
			if (pending_words.size() == 0) begin
				$error("unexpected word id=%0d ev=%0d", out_word.timer_id_res,
					out_word.event_res);
				errors++;
			end else begin
				e = pending_words.pop_front();
				if (out_word.timer_id_res !== e.timer_id_res) begin
					$error("timer_id_res: expected %0d, actual %0d", e.timer_id_res,
						out_word.timer_id_res);
					errors++;
				end
				if (out_word.event_res !== e.event_res) begin
					$error("event_res: expected %0d, actual %0d", e.event_res,
						out_word.event_res);
					errors++;
				end
				if (out_word.last !== e.last) begin
					$error("last: expected %0d, actual %0d", e.last, out_word.last);
					errors++;
				end
			end
		end
	end

	function automatic dltq_pkg::in_word_t mk(logic [1:0] k, logic [3:0] id, logic [31:0] a);
		dltq_pkg::in_word_t w;
		w.kind = k;
		w.timer_id = id;
		w.amount = a;
		return w;
	endfunction

	task automatic send_word(dltq_pkg::in_word_t w);
		int gap;
		gap = 0;
		while (gap < 20 && $urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_word <= w;
		do @(posedge clk); while (!in_ready);
		predict_results(w);
		words_in++;
	endtask

	task automatic wait_drain();
		in_valid <= 1'b0;
		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (3 * dltq_pkg::NUM_TIMERS + 10) @(posedge clk);
	endtask

	task automatic test_directed_edges();
		send_word(mk(dltq_pkg::KIND_TICK, 4'd0, 32'd0));
		send_word(mk(dltq_pkg::KIND_TICK, 4'd7, 32'hFFFF_FFFF));
		send_word(mk(dltq_pkg::KIND_ATTACH, 4'd0, 32'd0));
		send_word(mk(dltq_pkg::KIND_ATTACH, 4'd15, 32'hFFFF_FFFF));
		send_word(mk(dltq_pkg::KIND_ATTACH, 4'd15, 32'd5));
		send_word(mk(dltq_pkg::KIND_DETACH, 4'd3, 32'd0));
		send_word(mk(dltq_pkg::KIND_ATTACH, 4'd1, 32'd10));
		send_word(mk(dltq_pkg::KIND_ATTACH, 4'd2, 32'd10));
		send_word(mk(dltq_pkg::KIND_ATTACH, 4'd3, 32'd4));
		send_word(mk(dltq_pkg::KIND_ATTACH, 4'd4, 32'd20));
		send_word(mk(dltq_pkg::KIND_DETACH, 4'd1, 32'd0));
		send_word(mk(dltq_pkg::KIND_TICK, 4'd0, 32'd3));
		send_word(mk(dltq_pkg::KIND_TICK, 4'd0, 32'd7));
		send_word(mk(2'd3, 4'd9, 32'h5A5A_A5A5));
		send_word(mk(dltq_pkg::KIND_DETACH, 4'd15, 32'd0));
		send_word(mk(dltq_pkg::KIND_TICK, 4'd0, 32'hFFFF_FFFF));
		wait_drain();
	endtask

	task automatic test_full_list();
		for (int i = 0; i < dltq_pkg::NUM_TIMERS; i++)
			send_word(mk(dltq_pkg::KIND_ATTACH, i[3:0], 32'($urandom_range(1, 8))));
		send_word(mk(dltq_pkg::KIND_ATTACH, 4'd5, 32'd1));
		send_word(mk(dltq_pkg::KIND_TICK, 4'd0, 32'd100));
		wait_drain();
	endtask

	function automatic logic [3:0] pick_id(logic want_active);
		logic [3:0] id;
		id = 4'($urandom_range(15));
		for (int i = 0; i < 16; i++)
			if (active_ids[4'(id + i)] == want_active)
				return 4'(id + i);
		return id;
	endfunction

	task automatic test_random_phase(int count, int spct, int rpct);
		int r;
		logic [31:0] a;
		send_idle_pct = spct;
		recv_idle_pct = rpct;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(99);
			a = ($urandom_range(9) == 0) ? 32'($urandom) : 32'($urandom_range(0, 40));
			if (r < 40)
				send_word(mk(dltq_pkg::KIND_ATTACH, pick_id(1'b0), a));
			else if (r < 65)
				send_word(mk(dltq_pkg::KIND_TICK, 4'($urandom),
					32'($urandom_range(0, 25))));
			else if (r < 85)
				send_word(mk(dltq_pkg::KIND_DETACH, pick_id(1'b1), 32'($urandom)));
			else
				send_word(mk(2'($urandom), 4'($urandom), 32'($urandom)));
		end
		wait_drain();
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_left = 400;
		for (int i = 0; i < 30; i++)
			send_word(mk(i[0] ? dltq_pkg::KIND_TICK : dltq_pkg::KIND_ATTACH, 4'($urandom),
				32'($urandom_range(1, 9))));
		wait_drain();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_word = '0;
		out_ready = 1'b0;
		hold_left = 0;
		errors = 0;
		words_in = 0;
		words_out = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		list_occ = 0;
		active_ids = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_edges();
		test_full_list();
		send_idle_pct = 36;
		recv_idle_pct = 47;
		test_random_phase(160, 36, 47);
		test_random_phase(160, 47, 36);
		test_backpressure();
		test_random_phase(150, 0, 0);
		$display("%0d words sent, %0d words received: edge cases, full list, back-pressure",
			words_in, words_out);
		$display("and random traffic under three idling mixes");
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
